// File: hdl/hindered_settling_factor_defines.svh
// Assertion macros shared by the hindered settling factor RTL.
`ifndef HINDERED_SETTLING_FACTOR_DEFINES_SVH
`define HINDERED_SETTLING_FACTOR_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define HSF_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("hsf assertion failed");
`define HSF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("hsf assertion failed");
`else
`define HSF_ASSERT_IMPL(lbl, ante, cons)
`define HSF_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// File: hdl/hsf_pkg.sv
// Package: types and constants of the hindered settling factor block.
`timescale 1ns / 1ps
`default_nettype none
package hsf_pkg;
    localparam int FRAC_BITS  = 16;
    localparam int QDEPTH     = 4;
    localparam int QPTR_W     = 2;
    localparam int QCNT_W     = 3;
    localparam int RE_W       = 48;
    localparam int DIV_STEPS  = 48;
    localparam int LOG_STEPS  = 16;
    localparam int LOG_W      = 22;
    localparam int RE_FRAC    = 12;
    localparam int EXP_BITS   = 16;
    localparam int SQ_PAIRS   = 17;
    localparam int SQ_CHUNK   = 6;
    localparam int SQ_NCH     = 3;
    localparam int EXP_STAGES = EXP_BITS * SQ_NCH;
    localparam int RCP_STEPS  = 18;

    localparam logic [47:0] RE_MAX     = 48'hFFFF_FFFF_FFFF;
    localparam logic [16:0] EXP_ONE    = 17'h10000;
    localparam logic [43:0] DEN_BASE   = 44'(40 * 65536);
    localparam logic [43:0] RCP_REM0   = 44'(94 * 16384);
    localparam logic [17:0] M_BASE     = 18'd88473;
    localparam logic [21:0] LOG_SIXTEEN = 22'h100000;

    typedef enum logic [0:0] {
        CFG_PACKING_LIMIT = 1'b0,
        CFG_DIAMETER      = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic [31:0] speed;
        logic [31:0] visc;
        logic [16:0] acomp;
        logic        packed_cell;
        logic        zero;
    } t_item;

    typedef struct packed {
        logic        packed_cell;
        logic        zero;
        logic        rez;
        logic [16:0] acomp;
        logic [5:0]  ip;
        logic [20:0] neg;
        logic [7:0]  n;
    } t_side;
endpackage
`default_nettype wire

// File: hdl/hsf_front.sv
// Front end: configuration registers, item classification and issue queue.
`timescale 1ns / 1ps
`default_nettype none
`include "hindered_settling_factor_defines.svh"
module hsf_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [15:0]          i_solids_fraction,
    input  logic [31:0]          i_terminal_speed,
    input  logic [31:0]          i_kinematic_viscosity,
    input  logic                 i_cfg_we,
    input  logic [0:0]           i_cfg_index,
    input  logic [31:0]          i_cfg_data,
    input  logic                 i_pop,
    output logic                 o_q_vld,
    output hsf_pkg::t_item       o_q_item,
    output logic [31:0]          o_diameter
);
    logic [15:0] r_limit, n_limit;
    logic [31:0] r_diam, n_diam;
    hsf_pkg::t_item r_mem [hsf_pkg::QDEPTH];
    logic [hsf_pkg::QPTR_W-1:0] r_wp, r_rp;
    logic [hsf_pkg::QCNT_W-1:0] r_cnt, n_cnt;
    hsf_pkg::t_item item;
    logic push;

    always_comb begin
        n_limit = r_limit;
        n_diam  = r_diam;
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                hsf_pkg::CFG_PACKING_LIMIT: n_limit = i_cfg_data[15:0];
                hsf_pkg::CFG_DIAMETER:      n_diam  = i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        item.speed       = i_terminal_speed;
        item.visc        = i_kinematic_viscosity;
        item.acomp       = 17'(hsf_pkg::EXP_ONE - {1'b0, i_solids_fraction});
        item.packed_cell = (i_solids_fraction >= r_limit);
        item.zero        = (i_kinematic_viscosity == '0);
    end

    assign o_stall = (r_cnt == hsf_pkg::QCNT_W'(hsf_pkg::QDEPTH));
    assign push    = i_valid && !o_stall;
    assign o_q_vld = (r_cnt != '0);
    assign o_q_item = r_mem[r_rp];
    assign o_diameter = r_diam;

    always_comb begin
        n_cnt = r_cnt;
        if (push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= 16'hFFFF;
            r_diam  <= '0;
            r_wp    <= '0;
            r_rp    <= '0;
            r_cnt   <= '0;
        end else begin
            r_limit <= n_limit;
            r_diam  <= n_diam;
            r_cnt   <= n_cnt;
            if (push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= item;
        end
    end

    `HSF_ASSERT_NEXT(a_cnt_up, push && !i_pop, r_cnt == $past(r_cnt) + 3'd1)
    `HSF_ASSERT_IMPL(a_pop_nonempty, i_pop, r_cnt != '0)
endmodule
`default_nettype wire

// File: hdl/hsf_log2.sv
// Two-lane pipelined log2: normalize, then one truncated squaring per stage.
`timescale 1ns / 1ps
`default_nettype none
module hsf_log2 (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_vld,
    input  logic [1:0][47:0]     i_v,
    input  hsf_pkg::t_side       i_side,
    output logic                 o_vld,
    output logic [1:0][21:0]     o_l,
    output hsf_pkg::t_side       o_side
);
    localparam int NS = hsf_pkg::LOG_STEPS + 1;

    logic                r_vld [NS];
    logic [1:0][5:0]     r_e   [NS];
    logic [1:0][16:0]    r_x   [NS];
    logic [1:0][15:0]    r_fr  [NS];
    hsf_pkg::t_side      r_side[NS];
    logic [1:0][5:0]     n_e   [NS];
    logic [1:0][16:0]    n_x   [NS];
    logic [1:0][15:0]    n_fr  [NS];

    for (genvar ln = 0; ln < 2; ln++) begin : g_norm
        always_comb begin
            logic [5:0] e;
            e = '0;
            for (int b = 0; b < 48; b++) begin
                if (i_v[ln][b]) begin
                    e = 6'(b);
                end
            end
            n_e[0][ln]  = e;
            n_fr[0][ln] = '0;
            if (e >= 6'd16) begin
                n_x[0][ln] = 17'(i_v[ln] >> (e - 6'd16));
            end else begin
                n_x[0][ln] = 17'(i_v[ln] << (6'd16 - e));
            end
        end
    end

    for (genvar k = 1; k < NS; k++) begin : g_sq
        for (genvar ln = 0; ln < 2; ln++) begin : g_lane
            logic [33:0] sq;
            assign sq = r_x[k-1][ln] * r_x[k-1][ln];
            always_comb begin
                n_e[k][ln] = r_e[k-1][ln];
                if (sq[33]) begin
                    n_x[k][ln]  = sq[33:17];
                    n_fr[k][ln] = {r_fr[k-1][ln][14:0], 1'b1};
                end else begin
                    n_x[k][ln]  = sq[32:16];
                    n_fr[k][ln] = {r_fr[k-1][ln][14:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NS; k++) r_vld[k] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_vld;
            for (int k = 1; k < NS; k++) r_vld[k] <= r_vld[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0] <= i_side;
            for (int k = 1; k < NS; k++) r_side[k] <= r_side[k-1];
            for (int k = 0; k < NS; k++) begin
                r_e[k]  <= n_e[k];
                r_x[k]  <= n_x[k];
                r_fr[k] <= n_fr[k];
            end
        end
    end

    assign o_vld  = r_vld[NS-1];
    assign o_side = r_side[NS-1];
    for (genvar ln = 0; ln < 2; ln++) begin : g_out
        assign o_l[ln] = {r_e[NS-1][ln], r_fr[NS-1][ln]};
    end
endmodule
`default_nettype wire

// File: hdl/hsf_exp2.sv
// Pipelined exp2 of a Q0.16 fraction: one digit-serial square root per bit.
`timescale 1ns / 1ps
`default_nettype none
module hsf_exp2 (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_vld,
    input  logic [15:0]          i_frac,
    input  hsf_pkg::t_side       i_side,
    output logic                 o_vld,
    output logic [16:0]          o_y,
    output hsf_pkg::t_side       o_side
);
    localparam int NS = hsf_pkg::EXP_STAGES;

    logic            r_vld [NS];
    logic [16:0]     r_root[NS];
    logic [18:0]     r_rem [NS];
    logic [33:0]     r_v   [NS];
    logic [15:0]     r_f   [NS];
    hsf_pkg::t_side  r_side[NS];
    logic [16:0]     n_root[NS];
    logic [18:0]     n_rem [NS];
    logic [33:0]     n_v   [NS];

    for (genvar j = 0; j < NS; j++) begin : g_st
        localparam int SI   = j / hsf_pkg::SQ_NCH;
        localparam int SC   = j % hsf_pkg::SQ_NCH;
        localparam int KTOP = hsf_pkg::SQ_PAIRS - 1 - SC * hsf_pkg::SQ_CHUNK;
        localparam int CNT  = (KTOP + 1 < hsf_pkg::SQ_CHUNK) ? KTOP + 1 : hsf_pkg::SQ_CHUNK;
        logic [16:0] p_root;
        logic [18:0] p_rem;
        logic [33:0] p_v;
        logic [15:0] p_f;
        if (j == 0) begin : g_first
            assign p_root = hsf_pkg::EXP_ONE;
            assign p_rem  = '0;
            assign p_v    = '0;
            assign p_f    = i_frac;
        end else begin : g_next
            assign p_root = r_root[j-1];
            assign p_rem  = r_rem[j-1];
            assign p_v    = r_v[j-1];
            assign p_f    = r_f[j-1];
        end
        always_comb begin
            logic [16:0] root;
            logic [18:0] rem;
            logic [33:0] v;
            logic [17:0] yy;
            logic [20:0] acc;
            logic [20:0] trial;
            root = p_root;
            rem  = p_rem;
            v    = p_v;
            yy   = '0;
            acc  = '0;
            trial = '0;
            if (SC == 0) begin
                yy   = p_f[SI] ? {p_root, 1'b0} : {1'b0, p_root};
                v    = {yy, 16'b0};
                root = '0;
                rem  = '0;
            end
            for (int s = 0; s < CNT; s++) begin
                acc   = {rem, v[2*(KTOP-s)+1 -: 2]};
                trial = {2'b0, root, 2'b01};
                if (acc >= trial) begin
                    rem  = 19'(acc - trial);
                    root = {root[15:0], 1'b1};
                end else begin
                    rem  = acc[18:0];
                    root = {root[15:0], 1'b0};
                end
            end
            n_root[j] = root;
            n_rem[j]  = rem;
            n_v[j]    = v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NS; k++) r_vld[k] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_vld;
            for (int k = 1; k < NS; k++) r_vld[k] <= r_vld[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_f[0]    <= i_frac;
            r_side[0] <= i_side;
            for (int k = 1; k < NS; k++) begin
                r_f[k]    <= r_f[k-1];
                r_side[k] <= r_side[k-1];
            end
            for (int k = 0; k < NS; k++) begin
                r_root[k] <= n_root[k];
                r_rem[k]  <= n_rem[k];
                r_v[k]    <= n_v[k];
            end
        end
    end

    assign o_vld  = r_vld[NS-1];
    assign o_y    = r_root[NS-1];
    assign o_side = r_side[NS-1];
endmodule
`default_nettype wire

// File: hdl/hsf_back.sv
// Back end: Reynolds number, exponent, power and output register.
`timescale 1ns / 1ps
`default_nettype none
`include "hindered_settling_factor_defines.svh"
module hsf_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_q_vld,
    input  hsf_pkg::t_item       i_q_item,
    output logic                 o_pop,
    input  logic [31:0]          i_diameter,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [16:0]          o_hindrance_factor,
    output logic                 o_zero_viscosity
);
    localparam int ND = hsf_pkg::DIV_STEPS + 1;
    localparam int NR = hsf_pkg::RCP_STEPS;

    logic en;
    logic r_out_vld;
    logic [16:0] r_out_h, n_out_h;
    logic r_out_zero;

    // product stage
    logic            r_m_vld;
    logic [63:0]     r_m_prod, n_m_prod;
    logic [31:0]     r_m_visc;
    hsf_pkg::t_side  r_m_side, n_m_side;

    // Reynolds divider
    logic            r_d_vld [ND];
    logic [31:0]     r_d_rem [ND];
    logic [47:0]     r_d_lo  [ND];
    logic [47:0]     r_d_q   [ND];
    logic [31:0]     r_d_visc[ND];
    logic            r_d_sat [ND];
    hsf_pkg::t_side  r_d_side[ND];
    logic [31:0]     n_d_rem [ND];
    logic [47:0]     n_d_lo  [ND];
    logic [47:0]     n_d_q   [ND];
    logic            n_d_sat;

    logic [47:0]     re;
    logic [1:0][47:0] log_in;
    hsf_pkg::t_side  log_side_in;
    logic            l_vld;
    logic [1:0][21:0] l_val;
    hsf_pkg::t_side  l_side;

    logic            r_p_vld;
    logic [15:0]     r_p_frac, n_p_frac;
    hsf_pkg::t_side  r_p_side, n_p_side;

    logic            e1_vld;
    logic [16:0]     e1_y;
    hsf_pkg::t_side  e1_side;

    logic            r_r_vld;
    logic [43:0]     r_r_den, n_r_den;
    hsf_pkg::t_side  r_r_side;

    logic            r_c_vld [NR];
    logic [43:0]     r_c_rem [NR];
    logic [17:0]     r_c_q   [NR];
    logic [43:0]     r_c_den [NR];
    hsf_pkg::t_side  r_c_side[NR];
    logic [43:0]     n_c_rem [NR];
    logic [17:0]     n_c_q   [NR];

    logic            r_mm_vld;
    logic [17:0]     r_mm_m;
    hsf_pkg::t_side  r_mm_side;

    logic            r_z_vld;
    logic [21:0]     r_z_z;
    hsf_pkg::t_side  r_z_side;
    logic [37:0]     zprod;

    logic            r_g_vld;
    logic [15:0]     r_g_frac, n_g_frac;
    hsf_pkg::t_side  r_g_side, n_g_side;

    logic            e2_vld;
    logic [16:0]     e2_y;
    hsf_pkg::t_side  e2_side;

    assign en    = !r_out_vld || !i_stall;
    assign o_pop = en && i_q_vld;

    always_comb begin
        n_m_prod = i_q_item.speed * i_diameter;
        n_m_side = '0;
        n_m_side.packed_cell = i_q_item.packed_cell;
        n_m_side.zero        = i_q_item.zero;
        n_m_side.acomp       = i_q_item.acomp;
    end

    // restoring division, one quotient bit per stage
    always_comb begin
        n_d_rem[0] = {16'b0, r_m_prod[63:48]};
        n_d_lo[0]  = r_m_prod[47:0];
        n_d_q[0]   = '0;
        n_d_sat    = r_m_side.zero || ({16'b0, r_m_prod[63:48]} >= r_m_visc);
    end

    for (genvar k = 1; k < ND; k++) begin : g_div
        logic [32:0] t_sum;
        logic        ge;
        assign t_sum = {r_d_rem[k-1], r_d_lo[k-1][47]};
        assign ge    = (t_sum >= {1'b0, r_d_visc[k-1]});
        always_comb begin
            n_d_rem[k] = ge ? 32'(t_sum - {1'b0, r_d_visc[k-1]}) : t_sum[31:0];
            n_d_lo[k]  = {r_d_lo[k-1][46:0], 1'b0};
            n_d_q[k]   = {r_d_q[k-1][46:0], ge};
        end
    end

    always_comb begin
        re = r_d_sat[ND-1] ? hsf_pkg::RE_MAX : r_d_q[ND-1];
        log_in[0] = re;
        log_in[1] = 48'(r_d_side[ND-1].acomp);
        log_side_in = r_d_side[ND-1];
        log_side_in.rez = (re == '0);
    end

    hsf_log2 u_log (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r_d_vld[ND-1]),
        .i_v     (log_in),
        .i_side  (log_side_in),
        .o_vld   (l_vld),
        .o_l     (l_val),
        .o_side  (l_side)
    );

    // 0.75 * log2(Re) and -log2(1-a)
    always_comb begin
        logic [23:0] trip;
        logic [21:0] negf;
        trip = {2'b0, l_val[0]} + {1'b0, l_val[0], 1'b0};
        negf = hsf_pkg::LOG_SIXTEEN - l_val[1];
        n_p_frac = trip[17:2];
        n_p_side = l_side;
        n_p_side.ip  = trip[23:18];
        n_p_side.neg = negf[20:0];
    end

    hsf_exp2 u_exp_re (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r_p_vld),
        .i_frac  (r_p_frac),
        .i_side  (r_p_side),
        .o_vld   (e1_vld),
        .o_y     (e1_y),
        .o_side  (e1_side)
    );

    always_comb begin
        logic [39:0] rq;
        if (e1_side.ip >= 6'(hsf_pkg::RE_FRAC)) begin
            rq = 40'(e1_y) << (e1_side.ip - 6'(hsf_pkg::RE_FRAC));
        end else begin
            rq = 40'(e1_y) >> (6'(hsf_pkg::RE_FRAC) - e1_side.ip);
        end
        if (e1_side.rez) begin
            rq = '0;
        end
        n_r_den = hsf_pkg::DEN_BASE + 44'({rq, 3'b0}) - 44'(rq);
    end

    // 94 * 2^32 / den, low dividend bits are zero
    for (genvar k = 0; k < NR; k++) begin : g_rcp
        logic [43:0] p_rem;
        logic [17:0] p_q;
        logic [43:0] p_den;
        logic [44:0] t_sum;
        logic        ge;
        if (k == 0) begin : g_first
            assign p_rem = hsf_pkg::RCP_REM0;
            assign p_q   = '0;
            assign p_den = r_r_den;
        end else begin : g_next
            assign p_rem = r_c_rem[k-1];
            assign p_q   = r_c_q[k-1];
            assign p_den = r_c_den[k-1];
        end
        assign t_sum = {p_rem, 1'b0};
        assign ge    = (t_sum >= {1'b0, p_den});
        always_comb begin
            n_c_rem[k] = ge ? 44'(t_sum - {1'b0, p_den}) : t_sum[43:0];
            n_c_q[k]   = {p_q[16:0], ge};
        end
    end

    assign zprod = r_mm_m * r_mm_side.neg;

    always_comb begin
        logic [22:0] nsum;
        logic [22:0] gfull;
        nsum  = {1'b0, r_z_z} + 23'h00FFFF;
        gfull = {nsum[22:16], 16'b0} - {1'b0, r_z_z};
        n_g_frac = gfull[15:0];
        n_g_side = r_z_side;
        n_g_side.n = 8'(nsum[22:16]);
    end

    hsf_exp2 u_exp_h (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r_g_vld),
        .i_frac  (r_g_frac),
        .i_side  (r_g_side),
        .o_vld   (e2_vld),
        .o_y     (e2_y),
        .o_side  (e2_side)
    );

    always_comb begin
        n_out_h = e2_side.packed_cell ? '0 : 17'(e2_y >> e2_side.n);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_vld   <= 1'b0;
            for (int k = 0; k < ND; k++) r_d_vld[k] <= 1'b0;
            r_p_vld   <= 1'b0;
            r_r_vld   <= 1'b0;
            for (int k = 0; k < NR; k++) r_c_vld[k] <= 1'b0;
            r_mm_vld  <= 1'b0;
            r_z_vld   <= 1'b0;
            r_g_vld   <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_m_vld   <= i_q_vld;
            r_d_vld[0] <= r_m_vld;
            for (int k = 1; k < ND; k++) r_d_vld[k] <= r_d_vld[k-1];
            r_p_vld   <= l_vld;
            r_r_vld   <= e1_vld;
            r_c_vld[0] <= r_r_vld;
            for (int k = 1; k < NR; k++) r_c_vld[k] <= r_c_vld[k-1];
            r_mm_vld  <= r_c_vld[NR-1];
            r_z_vld   <= r_mm_vld;
            r_g_vld   <= r_z_vld;
            r_out_vld <= e2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m_prod <= n_m_prod;
            r_m_visc <= i_q_item.visc;
            r_m_side <= n_m_side;
            r_d_visc[0] <= r_m_visc;
            r_d_sat[0]  <= n_d_sat;
            r_d_side[0] <= r_m_side;
            for (int k = 1; k < ND; k++) begin
                r_d_visc[k] <= r_d_visc[k-1];
                r_d_sat[k]  <= r_d_sat[k-1];
                r_d_side[k] <= r_d_side[k-1];
            end
            for (int k = 0; k < ND; k++) begin
                r_d_rem[k] <= n_d_rem[k];
                r_d_lo[k]  <= n_d_lo[k];
                r_d_q[k]   <= n_d_q[k];
            end
            r_p_frac <= n_p_frac;
            r_p_side <= n_p_side;
            r_r_den  <= n_r_den;
            r_r_side <= e1_side;
            r_c_den[0]  <= r_r_den;
            r_c_side[0] <= r_r_side;
            for (int k = 1; k < NR; k++) begin
                r_c_den[k]  <= r_c_den[k-1];
                r_c_side[k] <= r_c_side[k-1];
            end
            for (int k = 0; k < NR; k++) begin
                r_c_rem[k] <= n_c_rem[k];
                r_c_q[k]   <= n_c_q[k];
            end
            r_mm_m    <= hsf_pkg::M_BASE + r_c_q[NR-1];
            r_mm_side <= r_c_side[NR-1];
            r_z_z     <= zprod[37:16];
            r_z_side  <= r_mm_side;
            r_g_frac  <= n_g_frac;
            r_g_side  <= n_g_side;
            r_out_h    <= n_out_h;
            r_out_zero <= e2_side.zero;
        end
    end

    assign o_valid            = r_out_vld;
    assign o_hindrance_factor = r_out_h;
    assign o_zero_viscosity   = r_out_zero;

    `HSF_ASSERT_NEXT(a_out_load, en && e2_vld, r_out_vld)
    `HSF_ASSERT_NEXT(a_freeze_z, !en && r_z_vld, $stable(r_z_z))
    `HSF_ASSERT_NEXT(a_freeze_p, !en && r_p_vld, $stable(r_p_frac))
endmodule
`default_nettype wire

// File: hdl/hindered_settling_factor.sv
// Top level: hindered settling factor, front end plus pipelined back end.
// Throughput: one item per cycle while the output is not stalled; the back end
// is fully pipelined (dividers, log2 squarings and exp2 square roots each get
// their own stages).
// A 4-entry queue decouples input from the back end; output stall freezes it.
// Reset (synchronous, active low): queue empty, packing_limit 65535, diameter 0.
`timescale 1ns / 1ps
`default_nettype none
module hindered_settling_factor (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    output logic         o_stall,
    input  logic [15:0]  i_solids_fraction,
    input  logic [31:0]  i_terminal_speed,
    input  logic [31:0]  i_kinematic_viscosity,
    output logic         o_valid,
    input  logic         i_stall,
    output logic [16:0]  o_hindrance_factor,
    output logic         o_zero_viscosity,
    input  logic         i_cfg_we,
    input  logic [0:0]   i_cfg_index,
    input  logic [31:0]  i_cfg_data
);
    logic           q_vld;
    logic           pop;
    hsf_pkg::t_item q_item;
    logic [31:0]    diameter;

    hsf_front u_front (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_valid               (i_valid),
        .o_stall               (o_stall),
        .i_solids_fraction     (i_solids_fraction),
        .i_terminal_speed      (i_terminal_speed),
        .i_kinematic_viscosity (i_kinematic_viscosity),
        .i_cfg_we              (i_cfg_we),
        .i_cfg_index           (i_cfg_index),
        .i_cfg_data            (i_cfg_data),
        .i_pop                 (pop),
        .o_q_vld               (q_vld),
        .o_q_item              (q_item),
        .o_diameter            (diameter)
    );

    hsf_back u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_q_vld            (q_vld),
        .i_q_item           (q_item),
        .o_pop              (pop),
        .i_diameter         (diameter),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_hindrance_factor (o_hindrance_factor),
        .o_zero_viscosity   (o_zero_viscosity)
    );
endmodule
`default_nettype wire
